@@ rtl/lct_pkg.sv @@
package lct_pkg;

  // Fixed field widths
  localparam int ID_W          = 32;
  localparam int BYTES_W       = 16;
  localparam int FLAG_W        = 4;
  localparam int IMG_LEN_OUT_W = 9;
  localparam int CMD_LEN_OUT_W = 10;

  // Defaults for the top-level parameters
  localparam int ENTRIES_DEF       = 128;
  localparam int IMAGE_CHARS_DEF   = 256;
  localparam int COMMAND_CHARS_DEF = 512;

  // Operation codes
  localparam logic OP_REMEMBER = 1'b0;
  localparam logic OP_TAKE     = 1'b1;

  // Bit positions in the stored flag word
  localparam int FLAG_IMG_P = 0;
  localparam int FLAG_IMG_T = 1;
  localparam int FLAG_CMD_P = 2;
  localparam int FLAG_CMD_T = 3;

  typedef struct packed {
    logic               op;
    logic [ID_W-1:0]    process_id;
    logic [ID_W-1:0]    parent_id;
    logic [ID_W-1:0]    creator_id;
    logic               image_present;
    logic               image_truncated;
    logic               command_present;
    logic               command_truncated;
    logic [BYTES_W-1:0] image_bytes;
    logic [BYTES_W-1:0] command_bytes;
  } lct_req_t;

  typedef struct packed {
    logic                     hit;
    logic [ID_W-1:0]          parent_out;
    logic [ID_W-1:0]          creator_out;
    logic                     parent_known;
    logic                     creator_known;
    logic                     image_present_out;
    logic                     image_truncated_out;
    logic                     command_present_out;
    logic                     command_truncated_out;
    logic                     strings_replayed;
    logic [IMG_LEN_OUT_W-1:0] image_len_out;
    logic [CMD_LEN_OUT_W-1:0] command_len_out;
  } lct_rsp_t;

  // Write enables toward the table storage
  typedef struct packed {
    logic key_we;
    logic dat_we;
  } lct_mem_ctl_t;

endpackage

@@ rtl/lct_in_if.sv @@
interface lct_in_if;
  import lct_pkg::*;

  logic     valid;
  logic     ready;
  lct_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lct_out_if.sv @@
interface lct_out_if;
  import lct_pkg::*;

  logic     valid;
  logic     ready;
  lct_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lineage_cache_table_core.sv @@
// Channel  Direction  Payload    Handshake
// in_ch    sink       lct_req_t  valid/ready, taken only while idle
// out_ch   source     lct_rsp_t  valid/ready, one registered result slot
//
// A remember or a take first scans the key array; a take that hits then reads and
// drops the entry. The scan steps one key compare per cycle through the single
// read port of the key array. A zero-key request skips the scan.
// After reset a clearing pass zeroes the key array; in_ch is not ready meanwhile.
// A result waiting on out_ch does not block a remember;
// a take holds in its final step until the result slot frees.
module lineage_cache_table_core #(
  parameter int ENTRIES       = lct_pkg::ENTRIES_DEF,
  parameter int IMAGE_CHARS   = lct_pkg::IMAGE_CHARS_DEF,
  parameter int COMMAND_CHARS = lct_pkg::COMMAND_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lct_in_if.sink    in_ch,
  lct_out_if.source out_ch
);
  import lct_pkg::*;

  localparam int IW        = $clog2(ENTRIES);
  localparam int CW        = $clog2(ENTRIES + 1);
  localparam int IMG_LIMIT = (IMAGE_CHARS - 1) * 2;
  localparam int CMD_LIMIT = (COMMAND_CHARS - 1) * 2;
  localparam int ILW       = $clog2(IMG_LIMIT + 1);
  localparam int CLW       = $clog2(CMD_LIMIT + 1);
  localparam int DW        = 2 * ID_W + FLAG_W + ILW + CLW;

  localparam logic [CW-1:0]      LAST_C   = CW'(ENTRIES - 1);
  localparam logic [CW-1:0]      END_C    = CW'(ENTRIES);
  localparam logic [IW-1:0]      LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [BYTES_W-1:0] IMG_LIM  = BYTES_W'(IMG_LIMIT);
  localparam logic [BYTES_W-1:0] CMD_LIM  = BYTES_W'(CMD_LIMIT);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]   parent;
    logic [ID_W-1:0]   creator;
    logic [FLAG_W-1:0] flags;
    logic [ILW-1:0]    ilen;
    logic [CLW-1:0]    clen;
  } entry_t;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] victim_r, victim_nxt;
  lct_req_t      req_r;
  lct_rsp_t      rsp_r, rsp_nxt;
  logic          out_valid_r;
  lct_rsp_t      out_data_r;

  lct_mem_ctl_t    mem_ctl;
  logic [IW-1:0]   key_waddr, key_raddr, dat_addr;
  logic [ID_W-1:0] key_wdata, key_rdata;
  logic [DW-1:0]   dat_wdata, dat_rdata;

  logic          scan_start, scan_issue, out_load, in_fire;
  logic          m_found, m_empty;
  logic [IW-1:0] m_idx, e_idx, sel_idx;

  logic [BYTES_W-1:0] img_clamp, cmd_clamp;
  entry_t             new_entry, rd_entry;
  logic               img_rep, cmd_rep;

  assign in_fire = in_ch.valid && in_ch.ready;

  lct_store #(.ENTRIES(ENTRIES), .DW(DW)) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .key_waddr (key_waddr),
    .key_wdata (key_wdata),
    .key_raddr (key_raddr),
    .key_rdata (key_rdata),
    .dat_addr  (dat_addr),
    .dat_wdata (dat_wdata),
    .dat_rdata (dat_rdata)
  );

  lct_match #(.ENTRIES(ENTRIES)) u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (scan_start),
    .issue       (scan_issue),
    .issue_idx   (key_raddr),
    .key         (req_r.process_id),
    .rd_key      (key_rdata),
    .found       (m_found),
    .match_idx   (m_idx),
    .empty_found (m_empty),
    .empty_idx   (e_idx)
  );

  // Clamp lengths to the buffer limit and round down to even
  always_comb begin
    img_clamp = (req_r.image_bytes > IMG_LIM) ? IMG_LIM : req_r.image_bytes;
    cmd_clamp = (req_r.command_bytes > CMD_LIM) ? CMD_LIM : req_r.command_bytes;
    img_clamp[0] = 1'b0;
    cmd_clamp[0] = 1'b0;
    new_entry.parent  = req_r.parent_id;
    new_entry.creator = req_r.creator_id;
    new_entry.flags   = '0;
    new_entry.flags[FLAG_IMG_P] = req_r.image_present;
    new_entry.flags[FLAG_IMG_T] = req_r.image_truncated;
    new_entry.flags[FLAG_CMD_P] = req_r.command_present;
    new_entry.flags[FLAG_CMD_T] = req_r.command_truncated;
    new_entry.ilen = req_r.image_present ? ILW'(img_clamp) : '0;
    new_entry.clen = req_r.command_present ? CLW'(cmd_clamp) : '0;
  end

  // Derive the take result from the stored entry
  always_comb begin
    rd_entry = entry_t'(dat_rdata);
    img_rep  = rd_entry.flags[FLAG_IMG_P] && (rd_entry.ilen != '0);
    cmd_rep  = rd_entry.flags[FLAG_CMD_P] && (rd_entry.clen != '0);
  end

  // Pick the write slot: matching entry, else first empty, else victim
  always_comb begin
    priority if (m_found) begin
      sel_idx = m_idx;
    end else if (m_empty) begin
      sel_idx = e_idx;
    end else begin
      sel_idx = victim_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    victim_nxt = victim_r;
    rsp_nxt    = rsp_r;
    mem_ctl    = '0;
    key_waddr  = cnt_r[IW-1:0];
    key_wdata  = '0;
    key_raddr  = cnt_r[IW-1:0];
    dat_addr   = m_idx;
    dat_wdata  = DW'(new_entry);
    scan_start = 1'b0;
    scan_issue = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_ctl.key_we = 1'b1;
        if (cnt_r == LAST_C) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.data.process_id == '0) begin
            rsp_nxt = '0;
            if (in_ch.data.op == OP_TAKE) begin
              state_nxt = S_OUT;
            end
          end else begin
            cnt_nxt    = '0;
            scan_start = 1'b1;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r == END_C) begin
          state_nxt = S_DECIDE;
        end else begin
          scan_issue = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      S_DECIDE: begin
        if (req_r.op == OP_REMEMBER) begin
          mem_ctl.key_we = 1'b1;
          mem_ctl.dat_we = 1'b1;
          key_waddr      = sel_idx;
          key_wdata      = req_r.process_id;
          dat_addr       = sel_idx;
          if (!m_found && !m_empty) begin
            victim_nxt = (victim_r == LAST_IDX) ? '0 : victim_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end else if (m_found) begin
          state_nxt = S_READ;
        end else begin
          rsp_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_READ: begin
        // Drop the entry and form the hit result
        mem_ctl.key_we = 1'b1;
        key_waddr      = m_idx;
        rsp_nxt.hit                   = 1'b1;
        rsp_nxt.parent_out            = rd_entry.parent;
        rsp_nxt.creator_out           = rd_entry.creator;
        rsp_nxt.parent_known          = rd_entry.parent != '0;
        rsp_nxt.creator_known         = rd_entry.creator != '0;
        rsp_nxt.image_present_out     = img_rep;
        rsp_nxt.image_truncated_out   = img_rep && rd_entry.flags[FLAG_IMG_T];
        rsp_nxt.command_present_out   = cmd_rep;
        rsp_nxt.command_truncated_out = cmd_rep && rd_entry.flags[FLAG_CMD_T];
        rsp_nxt.strings_replayed      = img_rep || cmd_rep;
        rsp_nxt.image_len_out   = img_rep ? IMG_LEN_OUT_W'(rd_entry.ilen) : '0;
        rsp_nxt.command_len_out = cmd_rep ? CMD_LEN_OUT_W'(rd_entry.clen) : '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      cnt_r    <= '0;
      victim_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      victim_r <= victim_nxt;
    end
  end

  // Hold the accepted transaction and the pending result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_ch.data;
    end
    rsp_r <= rsp_nxt;
  end

  // Output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= rsp_r;
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result slot loaded outside the output step");

  a_victim_move: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(victim_r)) |->
      $past(state_r == S_DECIDE && req_r.op == OP_REMEMBER && !m_found && !m_empty))
    else $error("victim pointer moved without a replacement");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_ctl.key_we && !mem_ctl.dat_we)
    else $error("table written during a scan");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.data.hit) |-> (out_ch.data == '0))
    else $error("miss result carries nonzero fields");
`endif

endmodule

@@ rtl/lct_store.sv @@
module lct_store #(
  parameter int ENTRIES = lct_pkg::ENTRIES_DEF,
  parameter int DW      = 2 * lct_pkg::ID_W
) (
  input  logic                       clk,
  input  lct_pkg::lct_mem_ctl_t      ctl,
  input  logic [$clog2(ENTRIES)-1:0] key_waddr,
  input  logic [lct_pkg::ID_W-1:0]   key_wdata,
  input  logic [$clog2(ENTRIES)-1:0] key_raddr,
  output logic [lct_pkg::ID_W-1:0]   key_rdata,
  input  logic [$clog2(ENTRIES)-1:0] dat_addr,
  input  logic [DW-1:0]              dat_wdata,
  output logic [DW-1:0]              dat_rdata
);
  import lct_pkg::*;

  logic [ID_W-1:0] key_mem [ENTRIES];
  logic [DW-1:0]   dat_mem [ENTRIES];

  // Key array: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rdata <= key_mem[key_raddr];
  end

  // Payload array: single port, registered read
  always_ff @(posedge clk) begin
    if (ctl.dat_we) begin
      dat_mem[dat_addr] <= dat_wdata;
    end
    dat_rdata <= dat_mem[dat_addr];
  end

endmodule

@@ rtl/lct_match.sv @@
module lct_match #(
  parameter int ENTRIES = lct_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       issue,
  input  logic [$clog2(ENTRIES)-1:0] issue_idx,
  input  logic [lct_pkg::ID_W-1:0]   key,
  input  logic [lct_pkg::ID_W-1:0]   rd_key,
  output logic                       found,
  output logic [$clog2(ENTRIES)-1:0] match_idx,
  output logic                       empty_found,
  output logic [$clog2(ENTRIES)-1:0] empty_idx
);
  import lct_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  logic          cmp_v_r;
  logic [IW-1:0] cmp_idx_r;
  logic          found_r;
  logic [IW-1:0] match_idx_r;
  logic          empty_r;
  logic [IW-1:0] empty_idx_r;

  // Delay the issued index to line up with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
    end else begin
      cmp_v_r <= issue;
    end
    cmp_idx_r <= issue_idx;
  end

  // Shared comparator: record the first matching and the first empty entry
  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      found_r <= 1'b0;
      empty_r <= 1'b0;
    end else if (cmp_v_r) begin
      if (!found_r && rd_key == key) begin
        found_r <= 1'b1;
      end
      if (!empty_r && rd_key == '0) begin
        empty_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_v_r && !found_r && rd_key == key) begin
      match_idx_r <= cmp_idx_r;
    end
    if (cmp_v_r && !empty_r && rd_key == '0) begin
      empty_idx_r <= cmp_idx_r;
    end
  end

  assign found       = found_r;
  assign match_idx   = match_idx_r;
  assign empty_found = empty_r;
  assign empty_idx   = empty_idx_r;

endmodule

@@ verif/lineage_cache_table_core_test.sv @@
module lineage_cache_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lct_pkg::*;

  localparam int          ENTRIES       = ENTRIES_DEF;
  localparam int unsigned IMAGE_CAP     = (IMAGE_CHARS_DEF - 1) * 2;
  localparam int unsigned COMMAND_CAP   = (COMMAND_CHARS_DEF - 1) * 2;
  localparam int          RANDOM_ITEMS  = 1530;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  // Lineage table mirror: predicts take results and queues them in order
  class lineage_scoreboard;
    logic [ID_W-1:0]          held_key[ENTRIES];
    logic [ID_W-1:0]          held_parent[ENTRIES];
    logic [ID_W-1:0]          held_creator[ENTRIES];
    logic [FLAG_W-1:0]        held_flags[ENTRIES];
    logic [IMG_LEN_OUT_W-1:0] held_image_len[ENTRIES];
    logic [CMD_LEN_OUT_W-1:0] held_command_len[ENTRIES];
    int unsigned              victim;
    lct_rsp_t                 lineage_q[$];
    int unsigned              remembers, takes, hits, evictions, errors;

    function new();
      for (int i = 0; i < ENTRIES; i++) drop_entry(i);
      victim = 0;
    endfunction

    function void drop_entry(int i);
      held_key[i]         = '0;
      held_parent[i]      = '0;
      held_creator[i]     = '0;
      held_flags[i]       = '0;
      held_image_len[i]   = '0;
      held_command_len[i] = '0;
    endfunction

    // Clamp to the string capacity and round down to even
    function int unsigned clamp_even(logic [BYTES_W-1:0] bytes, int unsigned cap);
      int unsigned b;
      b = (bytes > cap) ? cap : bytes;
      return b & ~32'd1;
    endfunction

    function void store_lineage(lct_req_t r);
      int slot;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (held_key[i] == r.process_id) begin
          slot = i;
          break;
        end
        if (held_key[i] == '0 && slot < 0) slot = i;
      end
      // Table full: replace the round-robin victim
      if (slot < 0) begin
        slot = victim;
        victim = (victim + 1) % ENTRIES;
        evictions++;
      end
      drop_entry(slot);
      held_key[slot]     = r.process_id;
      held_parent[slot]  = r.parent_id;
      held_creator[slot] = r.creator_id;
      held_flags[slot]   = {r.command_truncated, r.command_present,
                            r.image_truncated, r.image_present};
      if (r.image_present)
        held_image_len[slot] = IMG_LEN_OUT_W'(clamp_even(r.image_bytes, IMAGE_CAP));
      if (r.command_present)
        held_command_len[slot] = CMD_LEN_OUT_W'(clamp_even(r.command_bytes, COMMAND_CAP));
    endfunction

    function lct_rsp_t take_lineage(logic [ID_W-1:0] key);
      lct_rsp_t   rsp;
      logic [3:0] f;
      bit         img, cmd;
      rsp = '0;
      if (key == '0) return rsp;
      for (int i = 0; i < ENTRIES; i++) begin
        if (held_key[i] == key) begin
          f   = held_flags[i];
          img = f[FLAG_IMG_P] && held_image_len[i] != '0;
          cmd = f[FLAG_CMD_P] && held_command_len[i] != '0;
          rsp.hit                   = 1'b1;
          rsp.parent_out            = held_parent[i];
          rsp.creator_out           = held_creator[i];
          rsp.parent_known          = held_parent[i] != '0;
          rsp.creator_known         = held_creator[i] != '0;
          rsp.image_present_out     = img;
          rsp.image_truncated_out   = img && f[FLAG_IMG_T];
          rsp.command_present_out   = cmd;
          rsp.command_truncated_out = cmd && f[FLAG_CMD_T];
          rsp.strings_replayed      = img || cmd;
          rsp.image_len_out         = img ? held_image_len[i] : '0;
          rsp.command_len_out       = cmd ? held_command_len[i] : '0;
          drop_entry(i);
          hits++;
          break;
        end
      end
      return rsp;
    endfunction

    // Note an accepted input transaction
    function void note_request(lct_req_t r);
      if (r.op == OP_REMEMBER) begin
        remembers++;
        if (r.process_id != '0) store_lineage(r);
      end else begin
        takes++;
        lineage_q.push_back(take_lineage(r.process_id));
      end
    endfunction

    function void check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Check an accepted result transaction against the oldest prediction
    function void check_result(lct_rsp_t got);
      lct_rsp_t want;
      if (lineage_q.size() == 0) begin
        $error("result transaction with no take pending");
        errors++;
        return;
      end
      want = lineage_q.pop_front();
      check_field("hit", want.hit, got.hit);
      check_field("parent_out", want.parent_out, got.parent_out);
      check_field("creator_out", want.creator_out, got.creator_out);
      check_field("parent_known", want.parent_known, got.parent_known);
      check_field("creator_known", want.creator_known, got.creator_known);
      check_field("image_present_out", want.image_present_out, got.image_present_out);
      check_field("image_truncated_out", want.image_truncated_out,
                  got.image_truncated_out);
      check_field("command_present_out", want.command_present_out,
                  got.command_present_out);
      check_field("command_truncated_out", want.command_truncated_out,
                  got.command_truncated_out);
      check_field("strings_replayed", want.strings_replayed, got.strings_replayed);
      check_field("image_len_out", want.image_len_out, got.image_len_out);
      check_field("command_len_out", want.command_len_out, got.command_len_out);
    endfunction

    function int pending();
      return lineage_q.size();
    endfunction

    // Random key currently held in the table; zero when the table is empty
    function logic [ID_W-1:0] pick_held_key();
      int idx[$];
      for (int i = 0; i < ENTRIES; i++)
        if (held_key[i] != '0) idx.push_back(i);
      if (idx.size() == 0) return '0;
      return held_key[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  bit          quiet;
  int unsigned cycle_count = 0;
  lineage_scoreboard sb;

  lct_in_if  in_ch();
  lct_out_if out_ch();

  lineage_cache_table_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Hard stop on a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short gaps, some medium, a few long; none in quiet stretches
  function automatic int unsigned pick_gap(int unsigned min_len);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet) return min_len;
    if (roll < 80) return $urandom_range(min_len, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTES_W-1:0] pick_bytes(int unsigned cap);
    case ($urandom_range(0, 5))
      0:       return BYTES_W'($urandom());
      1:       return BYTES_W'($urandom_range(0, 3));
      2:       return BYTES_W'(cap - 1 + $urandom_range(0, 2));
      default: return BYTES_W'($urandom_range(0, cap + 1));
    endcase
  endfunction

  function automatic lct_req_t make_req(logic op, logic [ID_W-1:0] pid,
                                        logic [ID_W-1:0] par, logic [ID_W-1:0] cre,
                                        logic [3:0] flags,
                                        logic [BYTES_W-1:0] ib, logic [BYTES_W-1:0] cb);
    lct_req_t r;
    r.op                = op;
    r.process_id        = pid;
    r.parent_id         = par;
    r.creator_id        = cre;
    r.image_present     = flags[FLAG_IMG_P];
    r.image_truncated   = flags[FLAG_IMG_T];
    r.command_present   = flags[FLAG_CMD_P];
    r.command_truncated = flags[FLAG_CMD_T];
    r.image_bytes       = ib;
    r.command_bytes     = cb;
    return r;
  endfunction

  // Mostly well-formed traffic: takes of held keys, overwrites, fresh keys
  function automatic lct_req_t random_request(int unsigned remember_pct);
    logic [ID_W-1:0] key;
    int unsigned     roll;
    logic            op;
    op   = ($urandom_range(0, 99) < remember_pct) ? OP_REMEMBER : OP_TAKE;
    roll = $urandom_range(0, 99);
    if (op == OP_REMEMBER) begin
      if (roll < 15)      key = sb.pick_held_key();
      else if (roll < 18) key = '0;
      else if (roll < 30) key = $urandom_range(1, 400);
      else                key = $urandom();
    end else begin
      if (roll < 65)      key = sb.pick_held_key();
      else if (roll < 70) key = '0;
      else if (roll < 80) key = $urandom_range(1, 400);
      else                key = $urandom();
    end
    return make_req(op, key,
                    ($urandom_range(0, 9) == 0) ? '0 : $urandom(),
                    ($urandom_range(0, 9) == 0) ? '0 : $urandom(),
                    FLAG_W'($urandom_range(0, 15)),
                    pick_bytes(IMAGE_CAP), pick_bytes(COMMAND_CAP));
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send_item(input lct_req_t req);
    int unsigned gap;
    gap = pick_gap(0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Result-side backpressure
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap(1)) @(posedge clk);
      end
    end
  end

  // Observe both channels
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  initial begin
    sb = new();
    quiet = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: misses, zero keys, extremes, flag and length corner cases
    send_item(make_req(OP_TAKE, 32'h1234, '0, '0, 4'h0, '0, '0));
    send_item(make_req(OP_REMEMBER, '0, 32'h55, 32'h66, 4'hF, 16'd40, 16'd50));
    send_item(make_req(OP_TAKE, '0, '0, '0, 4'h0, '0, '0));
    send_item(make_req(OP_REMEMBER, '1, '1, '1, 4'hF, '1, '1));
    send_item(make_req(OP_TAKE, '1, '0, '0, 4'h0, '0, '0));
    // truncated set without present: nothing replayed
    send_item(make_req(OP_REMEMBER, 32'd1, '0, '0, 4'b1010, 16'd100, 16'd200));
    send_item(make_req(OP_TAKE, 32'd1, '0, '0, 4'h0, '0, '0));
    // present but length rounds to zero
    send_item(make_req(OP_REMEMBER, 32'd2, 32'd7, '0, 4'b0111, 16'd1, 16'd0));
    send_item(make_req(OP_TAKE, 32'd2, '0, '0, 4'h0, '0, '0));
    // overwrite in place
    send_item(make_req(OP_REMEMBER, 32'd3, 32'd10, 32'd11, 4'b1101, 16'd509, 16'd1023));
    send_item(make_req(OP_REMEMBER, 32'd3, 32'd20, 32'd21, 4'b0111, 16'd510, 16'd1021));
    send_item(make_req(OP_TAKE, 32'd3, '0, '0, 4'h0, '0, '0));
    send_item(make_req(OP_TAKE, 32'd3, '0, '0, 4'h0, '0, '0));
    // image only, then command only
    send_item(make_req(OP_REMEMBER, 32'd4, 32'd1, 32'd2, 4'b1011, 16'd511, 16'd1000));
    send_item(make_req(OP_REMEMBER, 32'd5, 32'd3, 32'd4, 4'b1110, 16'd300, 16'd2));
    send_item(make_req(OP_TAKE, 32'd5, '0, '0, 4'h0, '0, '0));
    send_item(make_req(OP_TAKE, 32'd4, '0, '0, 4'h0, '0, '0));
    send_item(make_req(OP_REMEMBER, 32'h8000_0000, 32'd1, 32'h8000_0000, 4'b0101,
                       16'd2, 16'd3));
    send_item(make_req(OP_TAKE, 32'h8000_0000, '0, '0, 4'h0, '0, '0));
    send_item(make_req(OP_TAKE, '1, '0, '0, 4'h0, '0, '0));

    // Random: fill past capacity first, then balanced traffic
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 700 && n < 850);
      send_item(random_request((n < 500) ? 75 : 50));
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    do @(posedge clk); while (sb.pending() != 0);
    repeat (ENTRIES + 8) @(posedge clk);

    $display("Covered %0d remember and %0d take transactions: %0d hits, %0d evictions",
             sb.remembers, sb.takes, sb.hits, sb.evictions);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ lineage_cache_table_core.f @@
rtl/lct_pkg.sv
rtl/lct_in_if.sv
rtl/lct_out_if.sv
rtl/lct_store.sv
rtl/lct_match.sv
rtl/lineage_cache_table_core.sv
verif/lineage_cache_table_core_test.sv
